// ===== sv/die_pkg.sv =====
// ----------------------------------------------------------------------------
// die_pkg
// shared types and constants of the extended2 dispersion index pipeline
// ----------------------------------------------------------------------------
package die_pkg;

  localparam int CoefW      = 48;
  localparam int NumCoef    = 8;
  localparam int CoefIdxW   = $clog2(NumCoef);
  localparam int WaveW      = 30;
  localparam int SqW        = 2 * WaveW;
  localparam int PowW       = 64;
  localparam int HalfW      = PowW / 2;
  localparam int MagHalfW   = CoefW / 2;
  localparam int RemW       = SqW + 1;
  localparam int RndSh      = 16;
  localparam int RcpStages  = 32;
  localparam int RcpBits    = PowW / RcpStages;
  localparam int ProdW      = CoefW + PowW;
  localparam int AccW       = ProdW + 4;
  localparam int IdxW       = 32;
  localparam int StatW      = 2;
  localparam int SqrtStages = 16;
  localparam int SqrtBits   = IdxW / SqrtStages;

  localparam int FrontLat   = 2;
  localparam int PowLat     = 5;
  localparam int TermLat    = 7;
  localparam int FinalLat   = 1;
  localparam int OutLat     = 1;
  localparam int TotalLat   = FrontLat + RcpStages + PowLat + TermLat + FinalLat +
                              SqrtStages + OutLat;

  typedef enum logic [StatW-1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_NEG  = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  typedef enum logic [CoefIdxW-1:0] {
    C_CONST = 3'd0,
    C_LSQ   = 3'd1,
    C_INV2  = 3'd2,
    C_INV4  = 3'd3,
    C_INV6  = 3'd4,
    C_INV8  = 3'd5,
    C_L4    = 3'd6,
    C_L6    = 3'd7
  } coef_idx_t;

  typedef struct packed {
    logic vld;
    logic zero;
  } ctl_t;

  typedef logic [PowW-1:0]  pow_t;
  typedef pow_t [NumCoef-1:0] pow_arr_t;
  typedef logic [CoefW-1:0] coef_t;
  typedef coef_t [NumCoef-1:0] coef_arr_t;

endpackage

// ===== sv/dispersion_index_extended2.sv =====
// ----------------------------------------------------------------------------
// dispersion_index_extended2
// refractive index from wavelength, extended2 glass dispersion formula
// ----------------------------------------------------------------------------
//  channel   ports                              handshake
//  input     start, busy, in_wavelength          start && !busy
//  result    out_valid, out_index, out_status    out_valid, one cycle
//  config    cfg_we, cfg_addr, cfg_wdata          cfg_we
//
//  one transaction per cycle
//  pipeline includes the 32 stage divider and the 16 stage square root
//  busy stays low; the result channel cannot stall
//  synchronous reset clears all valid bits and coefficients
// ----------------------------------------------------------------------------
module dispersion_index_extended2 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [die_pkg::WaveW-1:0]         in_wavelength,
  output logic                              out_valid,
  output logic [die_pkg::IdxW-1:0]          out_index,
  output logic [die_pkg::StatW-1:0]         out_status,
  input  logic                              cfg_we,
  input  logic [die_pkg::CoefIdxW-1:0]      cfg_addr,
  input  logic [die_pkg::CoefW-1:0]         cfg_wdata
);

  localparam int AW = die_pkg::AccW;
  localparam int PW = die_pkg::PowW;
  localparam int RS = die_pkg::RndSh;

  die_pkg::coef_arr_t coef_r;

  logic                        vld0_r;
  logic [die_pkg::WaveW-1:0]   w0_r;
  die_pkg::ctl_t               ctl1_r;
  logic [die_pkg::SqW-1:0]     sq1_r;

  die_pkg::ctl_t               rcp_ctl;
  logic [die_pkg::SqW-1:0]     rcp_sq;
  die_pkg::pow_t               rcp_q;
  logic                        rcp_sat;

  die_pkg::ctl_t               pow_ctl;
  die_pkg::pow_arr_t           pow_pw;
  logic [die_pkg::NumCoef-1:0] pow_ps;

  die_pkg::ctl_t               trm_ctl;
  logic signed [AW-1:0]        trm_acc;
  logic                        trm_hit;

  logic signed [AW-1:0]        rnd;
  logic                        ovf;
  die_pkg::status_t            fin_st;
  logic                        fin_vld_r;
  die_pkg::status_t            fin_st_r;
  die_pkg::pow_t               fin_v_r;

  logic                        sq_vld;
  die_pkg::status_t            sq_st;
  logic [die_pkg::IdxW-1:0]    sq_root;

  logic                        out_valid_r;
  logic [die_pkg::IdxW-1:0]    out_index_r;
  die_pkg::status_t            out_status_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_we) begin
      coef_r[cfg_addr] <= cfg_wdata;
    end
  end

  // front end: capture and square
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      ctl1_r <= '0;
    end else begin
      vld0_r     <= start && !busy;
      ctl1_r.vld <= vld0_r;
      ctl1_r.zero <= (w0_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    w0_r  <= in_wavelength;
    sq1_r <= {{die_pkg::WaveW{1'b0}}, w0_r} * {{die_pkg::WaveW{1'b0}}, w0_r};
  end

  die_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (ctl1_r),
    .in_sq   (sq1_r),
    .out_ctl (rcp_ctl),
    .out_sq  (rcp_sq),
    .out_q   (rcp_q),
    .out_sat (rcp_sat)
  );

  die_pow u_pow (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (rcp_ctl),
    .in_sq   (rcp_sq),
    .in_q2   (rcp_q),
    .in_r2   (rcp_sat),
    .out_ctl (pow_ctl),
    .out_pw  (pow_pw),
    .out_ps  (pow_ps)
  );

  die_terms u_terms (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (pow_ctl),
    .in_pw   (pow_pw),
    .in_ps   (pow_ps),
    .coef    (coef_r),
    .out_ctl (trm_ctl),
    .out_acc (trm_acc),
    .out_hit (trm_hit)
  );

  // round to q8.56 and classify
  assign rnd = trm_acc + (AW'(1) << (RS - 1));
  assign ovf = |rnd[AW-1:PW+RS];

  always_comb begin
    priority if (trm_ctl.zero)   fin_st = die_pkg::ST_ZERO;
    else if (trm_hit)            fin_st = die_pkg::ST_SAT;
    else if (trm_acc[AW-1])      fin_st = die_pkg::ST_NEG;
    else if (ovf)                fin_st = die_pkg::ST_SAT;
    else                         fin_st = die_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else begin
      fin_vld_r <= trm_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    fin_st_r <= fin_st;
    fin_v_r  <= rnd[PW+RS-1:RS];
  end

  die_sqrt u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (fin_vld_r),
    .in_status  (fin_st_r),
    .in_v       (fin_v_r),
    .out_vld    (sq_vld),
    .out_status (sq_st),
    .out_root   (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= sq_st;
    unique case (sq_st)
      die_pkg::ST_OK:   out_index_r <= sq_root;
      die_pkg::ST_SAT:  out_index_r <= '1;
      die_pkg::ST_ZERO: out_index_r <= '0;
      die_pkg::ST_NEG:  out_index_r <= '0;
      default:          out_index_r <= '0;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_index  = out_index_r;
  assign out_status = out_status_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(die_pkg::TotalLat) out_valid)
    else $error("accepted transaction produced no result at the expected cycle");

  a_low_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == die_pkg::ST_ZERO || out_status == die_pkg::ST_NEG))
      |-> (out_index == '0))
    else $error("zero or negative status with nonzero index");

  a_sat_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == die_pkg::ST_SAT) |-> (out_index == '1))
    else $error("saturated status without full scale index");

endmodule

// ===== sv/die_mulq.sv =====
// ----------------------------------------------------------------------------
// die_mulq
// two stage q32.32 multiplier, rounded half up, saturating
// ----------------------------------------------------------------------------
module die_mulq (
  input  logic          clk,
  input  die_pkg::pow_t a,
  input  die_pkg::pow_t b,
  output die_pkg::pow_t prod,
  output logic          sat
);

  localparam int HW = die_pkg::HalfW;
  localparam int PW = die_pkg::PowW;
  localparam int WW = 2 * PW;

  logic [HW-1:0] a_lo, a_hi, b_lo, b_hi;
  logic [PW-1:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic [WW-1:0] sum;
  die_pkg::pow_t prod_r;
  logic          sat_r;

  assign a_lo = a[HW-1:0];
  assign a_hi = a[PW-1:HW];
  assign b_lo = b[HW-1:0];
  assign b_hi = b[PW-1:HW];

  // partial products
  always_ff @(posedge clk) begin
    pp00_r <= {{HW{1'b0}}, a_lo} * {{HW{1'b0}}, b_lo};
    pp01_r <= {{HW{1'b0}}, a_lo} * {{HW{1'b0}}, b_hi};
    pp10_r <= {{HW{1'b0}}, a_hi} * {{HW{1'b0}}, b_lo};
    pp11_r <= {{HW{1'b0}}, a_hi} * {{HW{1'b0}}, b_hi};
  end

  assign sum = {{PW{1'b0}}, pp00_r} +
               {{HW{1'b0}}, pp01_r, {HW{1'b0}}} +
               {{HW{1'b0}}, pp10_r, {HW{1'b0}}} +
               {pp11_r, {PW{1'b0}}} +
               (WW'(1) << (HW - 1));

  always_ff @(posedge clk) begin
    sat_r  <= |sum[WW-1:PW+HW];
    prod_r <= (|sum[WW-1:PW+HW]) ? '1 : sum[PW+HW-1:HW];
  end

  assign prod = prod_r;
  assign sat  = sat_r;

endmodule

// ===== sv/die_recip.sv =====
// ----------------------------------------------------------------------------
// die_recip
// pipelined restoring divider, floor(2^80 / sq), two quotient bits per stage
// ----------------------------------------------------------------------------
module die_recip (
  input  logic                      clk,
  input  logic                      rst_n,
  input  die_pkg::ctl_t             in_ctl,
  input  logic [die_pkg::SqW-1:0]   in_sq,
  output die_pkg::ctl_t             out_ctl,
  output logic [die_pkg::SqW-1:0]   out_sq,
  output die_pkg::pow_t             out_q,
  output logic                      out_sat
);

  localparam int N  = die_pkg::RcpStages;
  localparam int RW = die_pkg::RemW;
  localparam int PW = die_pkg::PowW;
  localparam int SW = die_pkg::SqW;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [PW-1:0] q;
  } div_t;

  localparam logic [RW-1:0] RemInit = RW'(1) << die_pkg::RndSh;

  die_pkg::ctl_t  ctl_r [N];
  div_t           div_r [N];
  logic [SW-1:0]  d_r   [N];
  logic           sat_r [N];

  function automatic div_t div_step(div_t s, logic [SW-1:0] d);
    div_t r;
    r = s;
    for (int i = 0; i < die_pkg::RcpBits; i++) begin
      r.rem = {r.rem[RW-2:0], 1'b0};
      r.q   = {r.q[PW-2:0], 1'b0};
      if (r.rem >= {1'b0, d}) begin
        r.rem  = r.rem - {1'b0, d};
        r.q[0] = 1'b1;
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) ctl_r[k] <= '0;
    end else begin
      ctl_r[0] <= in_ctl;
      for (int k = 1; k < N; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    div_r[0] <= div_step('{rem: RemInit, q: '0}, in_sq);
    d_r[0]   <= in_sq;
    sat_r[0] <= {1'b0, in_sq} <= RemInit;
    for (int k = 1; k < N; k++) begin
      div_r[k] <= div_step(div_r[k-1], d_r[k-1]);
      d_r[k]   <= d_r[k-1];
      sat_r[k] <= sat_r[k-1];
    end
  end

  assign out_ctl = ctl_r[N-1];
  assign out_sq  = d_r[N-1];
  assign out_q   = sat_r[N-1] ? '1 : div_r[N-1].q;
  assign out_sat = sat_r[N-1];

endmodule

// ===== sv/die_pow.sv =====
// ----------------------------------------------------------------------------
// die_pow
// wavelength powers p2, p4, p6 and inverse powers q2, q4, q6, q8
// ----------------------------------------------------------------------------
module die_pow (
  input  logic                      clk,
  input  logic                      rst_n,
  input  die_pkg::ctl_t             in_ctl,
  input  logic [die_pkg::SqW-1:0]   in_sq,
  input  die_pkg::pow_t             in_q2,
  input  logic                      in_r2,
  output die_pkg::ctl_t             out_ctl,
  output die_pkg::pow_arr_t         out_pw,
  output logic [die_pkg::NumCoef-1:0] out_ps
);

  localparam int SW = die_pkg::SqW;
  localparam int PW = die_pkg::PowW;
  localparam int L  = die_pkg::PowLat;

  logic [SW:0]   rnd;
  die_pkg::ctl_t ctl_r [L];

  die_pkg::pow_t p2a_r, p2b_r, p2c_r, p2d_r, p2e_r;
  die_pkg::pow_t q2a_r, q2b_r, q2c_r, q2d_r, q2e_r;
  logic          r2a_r, r2b_r, r2c_r, r2d_r, r2e_r;
  die_pkg::pow_t p4, q4, p6, q6, q8;
  logic          s4m, r4m, s6m, r6m, r8m;
  die_pkg::pow_t p4d_r, p4e_r, q4d_r, q4e_r;
  logic          s4d_r, s4e_r, r4d_r, r4e_r;

  assign rnd = {1'b0, in_sq} + ((SW + 1)'(1) << (die_pkg::RndSh - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < L; k++) ctl_r[k] <= '0;
    end else begin
      ctl_r[0] <= in_ctl;
      for (int k = 1; k < L; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    p2a_r <= PW'(rnd[SW:die_pkg::RndSh]);
    q2a_r <= in_q2;
    r2a_r <= in_r2;
    p2b_r <= p2a_r;
    q2b_r <= q2a_r;
    r2b_r <= r2a_r;
    p2c_r <= p2b_r;
    q2c_r <= q2b_r;
    r2c_r <= r2b_r;
    p2d_r <= p2c_r;
    q2d_r <= q2c_r;
    r2d_r <= r2c_r;
    p2e_r <= p2d_r;
    q2e_r <= q2d_r;
    r2e_r <= r2d_r;
    p4d_r <= p4;
    p4e_r <= p4d_r;
    q4d_r <= q4;
    q4e_r <= q4d_r;
    s4d_r <= s4m;
    s4e_r <= s4d_r;
    r4d_r <= r2c_r | r4m;
    r4e_r <= r4d_r;
  end

  die_mulq u_p4 (.clk(clk), .a(p2a_r), .b(p2a_r), .prod(p4), .sat(s4m));
  die_mulq u_q4 (.clk(clk), .a(q2a_r), .b(q2a_r), .prod(q4), .sat(r4m));
  die_mulq u_p6 (.clk(clk), .a(p4),    .b(p2c_r), .prod(p6), .sat(s6m));
  die_mulq u_q6 (.clk(clk), .a(q4),    .b(q2c_r), .prod(q6), .sat(r6m));
  die_mulq u_q8 (.clk(clk), .a(q4),    .b(q4),    .prod(q8), .sat(r8m));

  always_comb begin
    out_pw                   = '0;
    out_pw[die_pkg::C_CONST] = PW'(1) << die_pkg::HalfW;
    out_pw[die_pkg::C_LSQ]   = p2e_r;
    out_pw[die_pkg::C_INV2]  = q2e_r;
    out_pw[die_pkg::C_INV4]  = q4e_r;
    out_pw[die_pkg::C_INV6]  = q6;
    out_pw[die_pkg::C_INV8]  = q8;
    out_pw[die_pkg::C_L4]    = p4e_r;
    out_pw[die_pkg::C_L6]    = p6;
    out_ps                   = '0;
    out_ps[die_pkg::C_INV2]  = r2e_r;
    out_ps[die_pkg::C_INV4]  = r4e_r;
    out_ps[die_pkg::C_INV6]  = r4e_r | r6m;
    out_ps[die_pkg::C_INV8]  = r4e_r | r8m;
    out_ps[die_pkg::C_L4]    = s4e_r;
    out_ps[die_pkg::C_L6]    = s4e_r | s6m;
  end

  assign out_ctl = ctl_r[L-1];

endmodule

// ===== sv/die_terms.sv =====
// ----------------------------------------------------------------------------
// die_terms
// coefficient times power for all eight terms and a registered adder tree
// ----------------------------------------------------------------------------
module die_terms (
  input  logic                          clk,
  input  logic                          rst_n,
  input  die_pkg::ctl_t                 in_ctl,
  input  die_pkg::pow_arr_t             in_pw,
  input  logic [die_pkg::NumCoef-1:0]   in_ps,
  input  die_pkg::coef_arr_t            coef,
  output die_pkg::ctl_t                 out_ctl,
  output logic signed [die_pkg::AccW-1:0] out_acc,
  output logic                          out_hit
);

  localparam int NC = die_pkg::NumCoef;
  localparam int CW = die_pkg::CoefW;
  localparam int MH = die_pkg::MagHalfW;
  localparam int HW = die_pkg::HalfW;
  localparam int PP = MH + HW;
  localparam int XW = die_pkg::ProdW;
  localparam int AW = die_pkg::AccW;
  localparam int L  = die_pkg::TermLat;

  die_pkg::ctl_t ctl_r [L];

  logic [CW-1:0]        mag1_r [NC];
  logic                 neg1_r [NC];
  die_pkg::pow_arr_t    pw1_r;
  logic                 hit1_r, hit2_r, hit3_r, hit4_r, hit5_r, hit6_r, hit7_r;
  logic [PP-1:0]        pp_r   [NC][4];
  logic                 neg2_r [NC];
  logic [XW-1:0]        mag3_r [NC];
  logic                 neg3_r [NC];
  logic signed [AW-1:0] t4_r   [NC];
  logic signed [AW-1:0] t5_r   [NC/2];
  logic signed [AW-1:0] t6_r   [NC/4];
  logic signed [AW-1:0] acc_r;
  logic [NC-1:0]        nz;

  always_comb begin
    for (int i = 0; i < NC; i++) nz[i] = |coef[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < L; k++) ctl_r[k] <= '0;
    end else begin
      ctl_r[0] <= in_ctl;
      for (int k = 1; k < L; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    // magnitude and sign
    for (int i = 0; i < NC; i++) begin
      neg1_r[i] <= coef[i][CW-1];
      mag1_r[i] <= coef[i][CW-1] ? (CW'(0) - coef[i]) : coef[i];
    end
    pw1_r  <= in_pw;
    hit1_r <= |(in_ps & nz);
    // partial products
    for (int i = 0; i < NC; i++) begin
      pp_r[i][0] <= {{HW{1'b0}}, mag1_r[i][MH-1:0]}  * {{MH{1'b0}}, pw1_r[i][HW-1:0]};
      pp_r[i][1] <= {{HW{1'b0}}, mag1_r[i][MH-1:0]}  * {{MH{1'b0}}, pw1_r[i][2*HW-1:HW]};
      pp_r[i][2] <= {{HW{1'b0}}, mag1_r[i][CW-1:MH]} * {{MH{1'b0}}, pw1_r[i][HW-1:0]};
      pp_r[i][3] <= {{HW{1'b0}}, mag1_r[i][CW-1:MH]} * {{MH{1'b0}}, pw1_r[i][2*HW-1:HW]};
      neg2_r[i]  <= neg1_r[i];
    end
    hit2_r <= hit1_r;
    // exact magnitude
    for (int i = 0; i < NC; i++) begin
      mag3_r[i] <= XW'(pp_r[i][0]) + (XW'(pp_r[i][1]) << HW) +
                   (XW'(pp_r[i][2]) << MH) + (XW'(pp_r[i][3]) << (HW + MH));
      neg3_r[i] <= neg2_r[i];
    end
    hit3_r <= hit2_r;
    // signed term
    for (int i = 0; i < NC; i++) begin
      t4_r[i] <= neg3_r[i] ? (AW'(0) - AW'(mag3_r[i])) : AW'(mag3_r[i]);
    end
    hit4_r <= hit3_r;
    // adder tree
    for (int i = 0; i < NC / 2; i++) t5_r[i] <= t4_r[2*i] + t4_r[2*i+1];
    hit5_r <= hit4_r;
    for (int i = 0; i < NC / 4; i++) t6_r[i] <= t5_r[2*i] + t5_r[2*i+1];
    hit6_r <= hit5_r;
    acc_r  <= t6_r[0] + t6_r[1];
    hit7_r <= hit6_r;
  end

  assign out_ctl = ctl_r[L-1];
  assign out_acc = acc_r;
  assign out_hit = hit7_r;

endmodule

// ===== sv/die_sqrt.sv =====
// ----------------------------------------------------------------------------
// die_sqrt
// pipelined integer square root of a 64 bit value, two result bits per stage
// ----------------------------------------------------------------------------
module die_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  die_pkg::status_t            in_status,
  input  die_pkg::pow_t               in_v,
  output logic                        out_vld,
  output die_pkg::status_t            out_status,
  output logic [die_pkg::IdxW-1:0]    out_root
);

  localparam int N  = die_pkg::SqrtStages;
  localparam int PW = die_pkg::PowW;

  typedef struct packed {
    logic [PW-1:0] v;
    logic [PW-1:0] res;
  } rt_t;

  logic             vld_r [N];
  die_pkg::status_t st_r  [N];
  rt_t              rt_r  [N];

  function automatic rt_t rt_step(rt_t s, int k);
    rt_t           r;
    logic [PW-1:0] one;
    r = s;
    for (int b = 0; b < die_pkg::SqrtBits; b++) begin
      one = PW'(1) << (PW - 2 - 2 * (die_pkg::SqrtBits * k + b));
      if (r.v >= r.res + one) begin
        r.v   = r.v - (r.res + one);
        r.res = (r.res >> 1) + one;
      end else begin
        r.res = r.res >> 1;
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < N; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    st_r[0] <= in_status;
    rt_r[0] <= rt_step('{v: in_v, res: '0}, 0);
    for (int k = 1; k < N; k++) begin
      st_r[k] <= st_r[k-1];
      rt_r[k] <= rt_step(rt_r[k-1], k);
    end
  end

  assign out_vld    = vld_r[N-1];
  assign out_status = st_r[N-1];
  assign out_root   = rt_r[N-1].res[die_pkg::IdxW-1:0];

endmodule
